// File: hdl/sse_pkg.sv
package sse_pkg;

	localparam int TERM_COUNT   = 16;
	localparam int SIG_SEGMENTS = 256;
	localparam int SEG_BITS     = $clog2(SIG_SEGMENTS);
	localparam int IDX_W        = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
	localparam int CNT_W        = $clog2(TERM_COUNT + 1);

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// 8.0 in Q32.32 and the sigmoid value 1.0 in Q1.16
	localparam logic signed [65:0] Z_EIGHT = 66'sd34359738368;
	localparam logic [16:0]        SIG_ONE = 17'd65536;

	localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [31:0] amplitude;
		logic [31:0] slope;
		logic [31:0] center;
	} term_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  entry;
		term_t       term;
	} wr_t;

	typedef struct packed {
		logic        en;
		logic [32:0] a;
		logic [32:0] b;
	} mul_req_t;

	typedef logic [15:0] sig_tab_t [0:SIG_SEGMENTS];

	// Unsigned quotient by restoring long division, for elaboration-time tables
	function automatic longint unsigned div_u64(longint unsigned dividend,
		longint unsigned divisor);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((dividend >> b) & 64'd1);
			quo = quo << 1;
			if (rem >= divisor) begin
				rem = rem - divisor;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// Sigmoid points in Q0.16 at x = -8 + 16*i/S, worked out at elaboration
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t              tab;
		longint unsigned       pt_off;
		longint unsigned       y;
		longint unsigned       term;
		longint unsigned       r;
		longint unsigned       num;
		longint unsigned       den;
		longint                acc;
		for (int i = 0; i <= SIG_SEGMENTS; i++) begin
			if (2 * i >= SIG_SEGMENTS)
				pt_off = 64'(2 * i - SIG_SEGMENTS);
			else
				pt_off = 64'(SIG_SEGMENTS - 2 * i);
			y    = (pt_off << 30) >> SEG_BITS;
			acc  = 64'sd2147483648;
			term = 64'd2147483648;
			for (int n = 1; n <= 12; n++) begin
				term = div_u64((term * y) >> 31, 64'(n));
				if ((n & 1) != 0)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			r = 64'(acc);
			for (int k = 0; k < 4; k++)
				r = (r * r) >> 31;
			num = (2 * i < SIG_SEGMENTS) ? r : 64'd2147483648;
			den = 64'd2147483648 + r;
			tab[i] = 16'(div_u64((num << 16) + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// File: hdl/sse_req_if.sv
interface sse_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  entry;
	logic [31:0] amplitude;
	logic [31:0] slope;
	logic [31:0] center;
	logic [31:0] key;

	modport source (output valid, kind, entry, amplitude, slope, center, key, input ready);
	modport sink   (input valid, kind, entry, amplitude, slope, center, key, output ready);
endinterface

// File: hdl/sse_rsp_if.sv
interface sse_rsp_if;
	logic        valid;
	logic        ready;
	logic [47:0] adjustment;
	logic        loaded;
	logic        overflow;

	modport source (output valid, adjustment, loaded, overflow, input ready);
	modport sink   (input valid, adjustment, loaded, overflow, output ready);
endinterface

// File: hdl/sigmoid_sum_evaluator_top.sv
// Sum-of-sigmoids evaluator. A write request (kind 0) stores amplitude, slope
// and center of one term in entry 0..15; a query request (kind 1) returns
// adjustment = sum of amplitude*sigmoid(slope*(key-center)) over the terms
// with nonzero amplitude, as signed Q32.16 saturated to 48 bits, with overflow
// set when the sum clipped. Before the first write since reset a query returns
// zero with loaded low. The sigmoid is a 257-point table over [-8,8) with
// linear interpolation, exactly 0 below and 1 at or above. All products go
// through one shared 33x33 multiplier, so a query walks the table one entry at
// a time: an empty entry passes through ST_WALK only, a loaded one through
// ST_WALK, ST_SEG, ST_IMUL and ST_AMUL (ST_IMUL skipped when the argument falls
// outside the table span). The block takes no request while a query is walking;
// a finished result sits in an output register until the sink takes it.
module sigmoid_sum_evaluator_top
	import sse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sse_req_if.sink    req,
	sse_rsp_if.source  rsp
);

	term_t            rd_term;
	wr_t              wr;
	mul_req_t         mreq;
	logic [65:0]      prod;
	logic [IDX_W-1:0] rd_idx;
	logic             loaded;

	// term table: amplitude cleared at reset, loaded flag set by any write
	sse_term_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_term (rd_term),
		.loaded  (loaded)
	);

	// shared multiplier: z, interpolation and amplitude products in turn
	sse_mul_unit u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// sequencer: walk entries, interpolate, accumulate, hold the result
	sse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_term (rd_term),
		.loaded  (loaded),
		.prod    (prod),
		.rd_idx  (rd_idx),
		.wr      (wr),
		.mreq    (mreq)
	);

	// a result from an empty table is zero with no overflow
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.loaded |-> (rsp.adjustment == '0) && !rsp.overflow)
		else $error("empty-table result is not zero");

	// a query holds off further requests while it walks the table
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.kind == KIND_QUERY) |=> !req.ready)
		else $error("request taken during a query");

	// an in-range write marks the table loaded
	a_write_loads: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.kind == KIND_WRITE)
		&& (32'(req.entry) < TERM_COUNT) |=> loaded)
		else $error("write did not mark the table loaded");

endmodule

// File: hdl/sse_term_store.sv
module sse_term_store
	import sse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  wr_t              wr,
	input  logic [IDX_W-1:0] rd_idx,
	output term_t            rd_term,
	output logic             loaded
);

	logic [31:0] amp_q    [TERM_COUNT];
	logic [31:0] slope_q  [TERM_COUNT];
	logic [31:0] center_q [TERM_COUNT];
	logic        loaded_q;
	logic        wr_hit;
	logic [IDX_W-1:0] wr_idx;

	// drop writes past the table end
	assign wr_hit = wr.en && (32'(wr.entry) < TERM_COUNT);
	assign wr_idx = IDX_W'(wr.entry);

	// a zero amplitude marks an empty entry, so only amplitude needs clearing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TERM_COUNT; i++)
				amp_q[i] <= '0;
			loaded_q <= 1'b0;
		end else if (wr_hit) begin
			amp_q[wr_idx] <= wr.term.amplitude;
			loaded_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			slope_q[wr_idx]  <= wr.term.slope;
			center_q[wr_idx] <= wr.term.center;
		end
	end

	assign rd_term.amplitude = amp_q[rd_idx];
	assign rd_term.slope     = slope_q[rd_idx];
	assign rd_term.center    = center_q[rd_idx];
	assign loaded            = loaded_q;

endmodule

// File: hdl/sse_mul_unit.sv
module sse_mul_unit
	import sse_pkg::*;
(
	input  logic        clk,
	input  mul_req_t    req,
	output logic [65:0] prod
);

	logic [65:0]        prod_q;
	logic signed [65:0] a_ext;
	logic signed [65:0] b_ext;

	assign a_ext = {{33{req.a[32]}}, req.a};
	assign b_ext = {{33{req.b[32]}}, req.b};

	// one signed 33x33 product, held until the next request
	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= a_ext * b_ext;
	end

	assign prod = prod_q;

endmodule

// File: hdl/sse_ctrl.sv
module sse_ctrl
	import sse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	sse_req_if.sink          req,
	sse_rsp_if.source        rsp,
	input  term_t            rd_term,
	input  logic             loaded,
	input  logic [65:0]      prod,
	output logic [IDX_W-1:0] rd_idx,
	output wr_t              wr,
	output mul_req_t         mreq
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_SEG  = 3'd2;
	localparam logic [2:0] ST_IMUL = 3'd3;
	localparam logic [2:0] ST_AMUL = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] idx_q;
	logic             acc_pend_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [31:0]      key_q;
	logic [47:0]      sum_q;
	logic             clamp_q;
	logic [16:0]      base_q;
	logic [16:0]      diff_q;
	logic [31:0]      frac_q;
	logic [47:0]      adj_q;
	logic             out_loaded_q;
	logic             out_ovf_q;

	logic             req_fire;
	logic             walk_done;
	logic             walk_finish;
	logic             out_free;
	logic             amp_zero;

	logic signed [48:0] sum_wide;
	logic [47:0]        sum_next;
	logic               ovf_next;

	logic signed [65:0] z;
	logic signed [65:0] u;
	logic [SEG_BITS-1:0] seg;
	logic [SEG_BITS:0]   seg_hi;
	logic [31:0]         frac;
	logic [15:0]         lo;
	logic [15:0]         hi;
	logic signed [16:0]  diff;
	logic                below;
	logic                above;

	logic signed [17:0]  s_wide;
	logic [16:0]         s_val;

	assign req_fire    = req.valid && req.ready;
	assign walk_done   = (idx_q == CNT_W'(TERM_COUNT));
	assign out_free    = !out_valid_q || rsp.ready;
	assign walk_finish = (state_q == ST_WALK) && walk_done && out_free;
	assign amp_zero    = (rd_term.amplitude == '0);
	assign rd_idx      = idx_q[IDX_W-1:0];

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.adjustment = adj_q;
	assign rsp.loaded     = out_loaded_q;
	assign rsp.overflow   = out_ovf_q;

	always_comb begin
		wr.en             = req_fire && (req.kind == KIND_WRITE);
		wr.entry          = req.entry;
		wr.term.amplitude = req.amplitude;
		wr.term.slope     = req.slope;
		wr.term.center    = req.center;
	end

	// saturating accumulate of the last amplitude product
	always_comb begin
		sum_wide = $signed({sum_q[47], sum_q}) + $signed({{16{prod[48]}}, prod[48:16]});
		sum_next = sum_q;
		ovf_next = ovf_q;
		if (acc_pend_q) begin
			if (sum_wide[48] != sum_wide[47]) begin
				sum_next = sum_wide[48] ? SUM_MIN : SUM_MAX;
				ovf_next = 1'b1;
			end else begin
				sum_next = sum_wide[47:0];
			end
		end
	end

	// segment lookup on z = slope*(key-center)
	always_comb begin
		z      = $signed(prod);
		below  = (z < -Z_EIGHT);
		above  = (z >= Z_EIGHT);
		u      = z + Z_EIGHT;
		seg    = u[35 -: SEG_BITS];
		seg_hi = {1'b0, seg} + 1'b1;
		frac   = 32'(u[35-SEG_BITS:0]) << (SEG_BITS - 4);
		lo     = SIG_TAB[seg];
		hi     = SIG_TAB[seg_hi];
		diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
	end

	// sigmoid value: base plus floored interpolation
	always_comb begin
		s_wide = $signed({1'b0, base_q});
		if (!clamp_q)
			s_wide = s_wide + $signed({prod[48], prod[48:32]});
		s_val = s_wide[16:0];
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_WALK: begin
				if (!walk_done && !amp_zero) begin
					mreq.en = 1'b1;
					mreq.a  = {rd_term.slope[31], rd_term.slope};
					mreq.b  = {key_q[31], key_q} - {rd_term.center[31], rd_term.center};
				end
			end
			ST_IMUL: begin
				mreq.en = 1'b1;
				mreq.a  = {{16{diff_q[16]}}, diff_q};
				mreq.b  = {1'b0, frac_q};
			end
			ST_AMUL: begin
				mreq.en = 1'b1;
				mreq.a  = {rd_term.amplitude[31], rd_term.amplitude};
				mreq.b  = {16'd0, s_val};
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			acc_pend_q   <= 1'b0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			sum_q        <= '0;
		end else begin
			// load a finished sum, or drop the held one once taken
			if (walk_finish)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.kind == KIND_QUERY)) begin
						// skip the walk when nothing is loaded
						idx_q      <= loaded ? '0 : CNT_W'(TERM_COUNT);
						sum_q      <= '0;
						ovf_q      <= 1'b0;
						acc_pend_q <= 1'b0;
						state_q    <= ST_WALK;
					end
				end
				ST_WALK: begin
					sum_q      <= sum_next;
					ovf_q      <= ovf_next;
					acc_pend_q <= 1'b0;
					if (walk_done) begin
						if (out_free)
							state_q <= ST_IDLE;
					end else if (amp_zero) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					state_q <= (below || above) ? ST_AMUL : ST_IMUL;
				end
				ST_IMUL: begin
					state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					acc_pend_q <= 1'b1;
					idx_q      <= idx_q + 1'b1;
					state_q    <= ST_WALK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire)
			key_q <= req.key;
		if (state_q == ST_SEG) begin
			clamp_q <= below || above;
			diff_q  <= diff;
			frac_q  <= frac;
			if (below)
				base_q <= '0;
			else if (above)
				base_q <= SIG_ONE;
			else
				base_q <= {1'b0, lo};
		end
		if (walk_finish) begin
			adj_q        <= sum_next;
			out_loaded_q <= loaded;
			out_ovf_q    <= ovf_next;
		end
	end

endmodule

// File: bench/sigmoid_sum_evaluator_check.sv
`timescale 1ns / 100ps

module sigmoid_sum_evaluator_check
	import sse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sse_req_if          req,
	sse_rsp_if          rsp,
	output int unsigned fails,
	output int unsigned outstanding
);

	localparam longint          ADJ_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint          ADJ_MIN = -ADJ_MAX - 1;
	localparam longint          Z_LIMIT = 64'sd34359738368;
	localparam longint unsigned Q31     = 64'd2147483648;
	localparam int unsigned     REPORT_LIMIT = 10;

	typedef struct packed {
		logic [47:0] adjustment;
		logic        loaded;
		logic        overflow;
	} sum_result_t;

	int          amp_tab    [TERM_COUNT];
	int          slope_tab  [TERM_COUNT];
	int          center_tab [TERM_COUNT];
	bit          any_written;
	int unsigned curve [0:SIG_SEGMENTS];
	sum_result_t expected_sums [$];
	int unsigned miss_total;

	// e^-(16*y) in Q0.31: truncated series, then squared four times
	function automatic longint unsigned exp_neg_q31(longint unsigned y);
		longint unsigned term;
		longint unsigned r;
		longint          acc;
		int              n;
		term = Q31;
		acc  = longint'(Q31);
		for (n = 1; n <= 12; n++) begin
			term = ((term * y) >> 31) / n;
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		r = unsigned'(acc);
		for (n = 0; n < 4; n++)
			r = (r * r) >> 31;
		return r;
	endfunction

	initial begin : build_curve
		longint unsigned span_pts;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		int              i;
		for (i = 0; i <= SIG_SEGMENTS; i++) begin
			if (2 * i >= SIG_SEGMENTS)
				span_pts = 64'(2 * i - SIG_SEGMENTS);
			else
				span_pts = 64'(SIG_SEGMENTS - 2 * i);
			e   = exp_neg_q31((span_pts << 30) / SIG_SEGMENTS);
			num = (2 * i < SIG_SEGMENTS) ? e : Q31;
			den = Q31 + e;
			curve[i] = 32'(((num << 16) + den / 2) / den);
		end
	end

	// sigmoid in Q0.16 of z in Q32.32, flat outside [-8,8)
	function automatic longint curve_at(longint z);
		longint unsigned scaled;
		longint unsigned seg;
		longint unsigned frac;
		longint          lo;
		longint          rise;
		if (z < -Z_LIMIT)
			return 0;
		if (z >= Z_LIMIT)
			return 65536;
		scaled = (unsigned'(z + Z_LIMIT) * SIG_SEGMENTS) >> 4;
		seg    = scaled >> 32;
		frac   = scaled & 64'hFFFF_FFFF;
		lo     = longint'(curve[seg]);
		rise   = longint'(curve[seg + 1]) - lo;
		return lo + ((rise * longint'(frac)) >>> 32);
	endfunction

	function automatic sum_result_t sum_of_terms(int key);
		sum_result_t res;
		longint      acc;
		longint      z;
		int          i;
		acc          = 0;
		res.loaded   = any_written;
		res.overflow = 1'b0;
		if (any_written) begin
			for (i = 0; i < TERM_COUNT; i++) begin
				if (amp_tab[i] != 0) begin
					z   = longint'(slope_tab[i]) * (longint'(key) - longint'(center_tab[i]));
					acc = acc + ((longint'(amp_tab[i]) * curve_at(z)) >>> 16);
					if (acc > ADJ_MAX) begin
						acc          = ADJ_MAX;
						res.overflow = 1'b1;
					end else if (acc < ADJ_MIN) begin
						acc          = ADJ_MIN;
						res.overflow = 1'b1;
					end
				end
			end
		end
		res.adjustment = acc[47:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		sum_result_t want;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < TERM_COUNT; i++) begin
				amp_tab[i]    = 0;
				slope_tab[i]  = 0;
				center_tab[i] = 0;
			end
			any_written = 1'b0;
			expected_sums.delete();
			miss_total  = 0;
			fails       <= 0;
			outstanding <= 0;
		end else begin
			// retire the response first: it always belongs to an older query
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_sums.size() == 0) begin
					if (miss_total < REPORT_LIMIT)
						$display("%0t: unexpected result adj %0d loaded %b ovf %b", $time,
							$signed(rsp.adjustment), rsp.loaded, rsp.overflow);
					miss_total++;
				end else begin
					want = expected_sums.pop_front();
					if (rsp.adjustment !== want.adjustment || rsp.loaded !== want.loaded ||
						rsp.overflow !== want.overflow) begin
						if (miss_total < REPORT_LIMIT)
							$display({"%0t: mismatch exp adj %0d loaded %b ovf %b,",
								" got adj %0d loaded %b ovf %b"},
								$time, $signed(want.adjustment), want.loaded, want.overflow,
								$signed(rsp.adjustment), rsp.loaded, rsp.overflow);
						miss_total++;
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.kind == KIND_QUERY) begin
					expected_sums.insert(expected_sums.size(),
						sum_of_terms(int'(signed'(req.key))));
				end else if (req.entry < TERM_COUNT) begin
					amp_tab[req.entry]    = int'(signed'(req.amplitude));
					slope_tab[req.entry]  = int'(signed'(req.slope));
					center_tab[req.entry] = int'(signed'(req.center));
					any_written           = 1'b1;
				end
			end
			fails       <= miss_total;
			outstanding <= expected_sums.size();
		end
	end

endmodule

// File: bench/sigmoid_sum_evaluator_top_tb.sv
`timescale 1ns / 100ps

module sigmoid_sum_evaluator_top_tb;
	import sse_pkg::*;

	// Random requests after the directed part.
	localparam int unsigned RANDOM_ITEMS  = 2000;
	// Worst case per request: a full 16-term walk, the longest sender gap and
	// the longest sink stall. Allow several times that for every request
	// being a query.
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	// Quiet time after the last result, about one full query walk.
	localparam int unsigned SETTLE_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	int unsigned fails;
	int unsigned outstanding;
	int unsigned cycle_count;
	int unsigned issued;
	// Set for stretches where neither side idles.
	bit          calm;
	// Centers last written, used to aim query keys into the sigmoid ramp.
	logic [31:0] recent_center [TERM_COUNT];

	sse_req_if req_bus ();
	sse_rsp_if rsp_bus ();

	sigmoid_sum_evaluator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	sigmoid_sum_evaluator_check sum_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.fails       (fails),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Q16.16 value: mostly within +/- 2^span raw units, sometimes full range or a corner.
	function automatic logic [31:0] q16_value(int unsigned span);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					2:       return 32'h0000_0000;
					3:       return 32'hFFFF_FFFF;
					4:       return 32'h0000_0001;
					default: return 32'h0001_0000;
				endcase
			end
			default: return $urandom_range(0, (32'd2 << span) - 1) - (32'd1 << span);
		endcase
	endfunction

	// Drop valid for the given idle length; scramble the payload meanwhile, it must not matter.
	task automatic hold_off(int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			req_bus.valid     = 1'b0;
			req_bus.kind      = 1'($urandom);
			req_bus.entry     = 4'($urandom);
			req_bus.amplitude = $urandom;
			req_bus.slope     = $urandom;
			req_bus.center    = $urandom;
			req_bus.key       = $urandom;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Present one request at the falling edge and hold it until a rising edge
	// sees ready. Valid stays high into the next request when there is no gap.
	task automatic push_request(logic kind, logic [3:0] entry, logic [31:0] amplitude,
		logic [31:0] slope, logic [31:0] center, logic [31:0] key);
		hold_off(calm ? 0 : gap_len());
		@(negedge clk);
		req_bus.valid     = 1'b1;
		req_bus.kind      = kind;
		req_bus.entry     = entry;
		req_bus.amplitude = amplitude;
		req_bus.slope     = slope;
		req_bus.center    = center;
		req_bus.key       = key;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		issued++;
	endtask

	// Store one term; the key field rides along with junk.
	task automatic write_term(logic [3:0] entry, logic [31:0] amplitude, logic [31:0] slope,
		logic [31:0] center);
		recent_center[entry] = center;
		push_request(KIND_WRITE, entry, amplitude, slope, center, $urandom);
	endtask

	// Query one key; the term fields ride along with junk.
	task automatic ask(logic [31:0] key);
		push_request(KIND_QUERY, 4'($urandom), $urandom, $urandom, $urandom, key);
	endtask

	// Hold the sender off until every outstanding result has been taken.
	task automatic drain();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Response sink: stall at random, never while calm starts a new stall.
	initial begin : response_sink
		int unsigned stall;
		stall         = 0;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall == 0 && !calm)
				stall = gap_len();
			if (stall > 0) begin
				rsp_bus.ready = 1'b0;
				stall--;
			end else begin
				rsp_bus.ready = 1'b1;
			end
		end
	end

	// Watchdog: end the run if it takes far longer than any correct run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned style;
		int unsigned terms;
		int unsigned queries;
		int unsigned slot;
		int unsigned stop_at;
		logic [3:0]  pick_entry;
		logic [31:0] amp;
		logic [31:0] key;

		// Drive every input to a known value before reset lets go.
		req_bus.valid     = 1'b0;
		req_bus.kind      = KIND_WRITE;
		req_bus.entry     = '0;
		req_bus.amplitude = '0;
		req_bus.slope     = '0;
		req_bus.center    = '0;
		req_bus.key       = '0;
		arst_n            = 1'b0;
		calm              = 1'b0;
		issued            = 0;
		for (slot = 0; slot < TERM_COUNT; slot++)
			recent_center[slot] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Nothing loaded yet: expect a zero sum with loaded low.
		ask(32'h0001_0000);
		// A zero-amplitude term marks the table loaded but adds nothing.
		write_term(4'd3, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		ask(32'h0001_0000);
		// Unit term at the last entry: walk the ramp edges around +/-8.
		write_term(4'd15, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
		ask(32'h0000_0000);
		ask(32'h0007_FFFF);
		ask(32'h0008_0000);
		ask(32'hFFF8_0000);
		ask(32'hFFF7_FFFF);
		ask(32'h7FFF_FFFF);
		ask(32'h8000_0000);
		// Field extremes in both directions, plus a gentle negative term.
		write_term(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		write_term(4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		write_term(4'd7, 32'hFFFF_0000, 32'h0000_1000, 32'h0003_0000);
		ask(32'h7FFF_FFFF);
		ask(32'h8000_0000);
		ask(32'h0003_0000);
		ask(32'h1234_5678);
		// Clear the unit term again, then a flat term with zero slope.
		write_term(4'd15, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		ask(32'h0000_0000);
		write_term(4'd9, 32'h0002_0000, 32'h0000_0000, $urandom);
		ask($urandom);
		drain();

		// Random rounds: mostly program a few terms and query around them,
		// now and then a full table, or noise with every field random.
		stop_at = issued + RANDOM_ITEMS;
		while (issued < stop_at) begin
			calm  = ($urandom_range(0, 5) == 0);
			style = $urandom_range(0, 9);
			if (style == 0) begin
				terms = $urandom_range(4, 16);
				repeat (terms)
					push_request(1'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
						$urandom);
			end else begin
				terms = (style == 1) ? TERM_COUNT : $urandom_range(1, 6);
				for (slot = 0; slot < terms; slot++) begin
					pick_entry = (style == 1) ? 4'(slot) : 4'($urandom);
					amp        = ($urandom_range(0, 9) == 0) ? 32'h0 : q16_value(20);
					write_term(pick_entry, amp, q16_value($urandom_range(10, 19)),
						q16_value(20));
				end
				queries = $urandom_range(1, 6);
				repeat (queries) begin
					if ($urandom_range(0, 1) == 1)
						key = recent_center[$urandom_range(0, TERM_COUNT - 1)] + q16_value(18);
					else
						key = q16_value(20);
					ask(key);
				end
			end
			// Now and then let the block run dry before the next round.
			if ($urandom_range(0, 11) == 0)
				drain();
		end
		calm = 1'b0;

		// Wait out every result, then one more walk for stray output.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/sse_pkg.sv
hdl/sse_req_if.sv
hdl/sse_rsp_if.sv
hdl/sse_term_store.sv
hdl/sse_mul_unit.sv
hdl/sse_ctrl.sv
hdl/sigmoid_sum_evaluator_top.sv
bench/sigmoid_sum_evaluator_check.sv
bench/sigmoid_sum_evaluator_top_tb.sv
